### rtl/core/rlb_pkg.sv
// Package for the RGBA8 layer blend: payload structs, mode codes, pipeline
// context and the divide-by-255 helper. No dependencies.
package rlb_pkg;

    localparam int ChanCount    = 3;
    localparam int DivStages    = 4;
    localparam int BitsPerStage = 2;

    typedef enum logic [2:0] {
        MODE_OVER    = 3'd0,
        MODE_REPLACE = 3'd1,
        MODE_ADD     = 3'd2,
        MODE_MUL     = 3'd3,
        MODE_SUB     = 3'd4
    } t_mode;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       changed;
    } t_out_item;

    // handed from the mixing pipe to the divider
    typedef struct packed {
        logic                           use_div;
        logic [ChanCount-1:0][16:0]     num;
        logic [7:0]                     den;
        t_out_item                      alt;
    } t_div_ctx;

    // floor(x/255) for x < 255 * 2^16: reciprocal estimate, low by at most one
    function automatic logic [15:0] div255(input logic [23:0] x);
        logic [40:0] p;
        logic [16:0] q;
        logic [24:0] r;
        p = 41'(x) * 41'd65793;
        q = p[40:24];
        r = 25'(x) - 25'(q) * 25'd255;
        if (r >= 25'd255) begin
            q = q + 17'd1;
        end
        return q[15:0];
    endfunction

endpackage

### rtl/core/rlb_mix.sv
// Six-stage mixing pipe: opacity scaling, products, /255 reductions and the
// non-divide blend modes. Depends on rlb_pkg.
module rlb_mix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rlb_pkg::t_in_item i_item,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_opacity,
    output logic             o_valid,
    output rlb_pkg::t_div_ctx o_ctx
);
    import rlb_pkg::*;

    logic [5:0] r_v;

    // stage 1
    t_in_item    r1_item;
    logic [2:0]  r1_mode;
    logic [15:0] r1_prod;
    // stage 2
    t_in_item    r2_item;
    logic [2:0]  r2_mode;
    logic [7:0]  r2_sa;
    // stage 3
    t_in_item    r3_item;
    logic [2:0]  r3_mode;
    logic [7:0]  r3_sa;
    logic [ChanCount-1:0][15:0] r3_ss, r3_ds, r3_dd;
    logic [15:0] r3_dinv;
    // stage 4
    t_in_item    r4_item;
    logic [2:0]  r4_mode;
    logic [7:0]  r4_sa;
    logic [ChanCount-1:0][15:0] r4_ss;
    logic [ChanCount-1:0][7:0]  r4_ks, r4_m;
    logic [ChanCount-1:0][23:0] r4_ddi;
    logic [7:0]  r4_dw;
    // stage 5
    t_in_item    r5_item;
    logic [2:0]  r5_mode;
    logic [7:0]  r5_sa;
    logic [ChanCount-1:0][15:0] r5_ss;
    logic [ChanCount-1:0][15:0] r5_ddiv;
    logic [ChanCount-1:0][16:0] r5_lerp;
    logic [ChanCount-1:0][7:0]  r5_add, r5_sub;
    logic [7:0]  r5_add_a, r5_ra;
    // stage 6
    t_div_ctx    r6_ctx;

    logic [ChanCount-1:0][7:0] s2, d2, d4;
    logic [ChanCount-1:0][7:0] s5, d5;

    always_comb begin
        s2 = {r2_item.src_red, r2_item.src_green, r2_item.src_blue};
        d2 = {r2_item.dst_red, r2_item.dst_green, r2_item.dst_blue};
        d4 = {r4_item.dst_red, r4_item.dst_green, r4_item.dst_blue};
        s5 = {r5_item.src_red, r5_item.src_green, r5_item.src_blue};
        d5 = {r5_item.dst_red, r5_item.dst_green, r5_item.dst_blue};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // stages 1 to 5: datapath
    always_ff @(posedge i_clk) begin
        logic [8:0] sum9;
        r1_item <= i_item;
        r1_mode <= i_mode;
        r1_prod <= 16'(i_item.src_alpha) * 16'(i_opacity);

        r2_item <= r1_item;
        r2_mode <= r1_mode;
        r2_sa   <= 8'(div255(24'(r1_prod)));

        r3_item <= r2_item;
        r3_mode <= r2_mode;
        r3_sa   <= r2_sa;
        for (int c = 0; c < ChanCount; c++) begin
            r3_ss[c] <= 16'(s2[c]) * 16'(r2_sa);
            r3_ds[c] <= 16'(d2[c]) * 16'(s2[c]);
            r3_dd[c] <= 16'(d2[c]) * 16'(r2_item.dst_alpha);
        end
        r3_dinv <= 16'(r2_item.dst_alpha) * 16'(8'd255 - r2_sa);

        r4_item <= r3_item;
        r4_mode <= r3_mode;
        r4_sa   <= r3_sa;
        r4_ss   <= r3_ss;
        for (int c = 0; c < ChanCount; c++) begin
            r4_ks[c]  <= 8'(div255(24'(r3_ss[c])));
            r4_m[c]   <= 8'(div255(24'(r3_ds[c])));
            r4_ddi[c] <= 24'(r3_dd[c]) * 24'(8'd255 - r3_sa);
        end
        r4_dw <= 8'(div255(24'(r3_dinv)));

        r5_item <= r4_item;
        r5_mode <= r4_mode;
        r5_sa   <= r4_sa;
        r5_ss   <= r4_ss;
        r5_ra   <= r4_sa + r4_dw;   // never above 255
        for (int c = 0; c < ChanCount; c++) begin
            r5_ddiv[c] <= div255(r4_ddi[c]);
            r5_lerp[c] <= 17'(16'(d4[c]) * 16'(8'd255 - r4_sa))
                        + 17'(16'(r4_m[c]) * 16'(r4_sa));
            sum9 = 9'(d4[c]) + 9'(r4_ks[c]);
            r5_add[c] <= sum9[8] ? 8'd255 : sum9[7:0];
            r5_sub[c] <= (d4[c] > r4_ks[c]) ? d4[c] - r4_ks[c] : 8'd0;
        end
        sum9 = 9'(r4_item.dst_alpha) + 9'(r4_sa);
        r5_add_a <= sum9[8] ? 8'd255 : sum9[7:0];
    end

    // stage 6: mode select, divider operands
    always_ff @(posedge i_clk) begin
        t_div_ctx ctx;
        logic [ChanCount-1:0][7:0] col;
        ctx.use_div = 1'b0;
        ctx.den     = r5_ra;
        for (int c = 0; c < ChanCount; c++) begin
            ctx.num[c] = 17'(r5_ss[c]) + 17'(r5_ddiv[c]);
        end
        col = d5;
        ctx.alt.out_alpha = r5_item.dst_alpha;
        ctx.alt.changed   = 1'b1;
        case (r5_mode)
            MODE_REPLACE: begin
                col = s5;
                ctx.alt.out_alpha = r5_sa;
            end
            MODE_ADD: begin
                col = r5_add;
                ctx.alt.out_alpha = r5_add_a;
            end
            MODE_MUL: begin
                for (int c = 0; c < ChanCount; c++) begin
                    col[c] = 8'(div255(24'(r5_lerp[c])));
                end
            end
            MODE_SUB: begin
                col = r5_sub;
            end
            default: begin
                // source-over; empty result alpha gives all zero
                col = '0;
                ctx.alt.out_alpha = r5_ra;
                ctx.use_div = (r5_ra != 8'd0);
            end
        endcase
        if (r5_sa == 8'd0 && r5_mode != MODE_REPLACE) begin
            col = d5;
            ctx.alt.out_alpha = r5_item.dst_alpha;
            ctx.alt.changed   = 1'b0;
            ctx.use_div       = 1'b0;
        end
        ctx.alt.out_red   = col[2];
        ctx.alt.out_green = col[1];
        ctx.alt.out_blue  = col[0];
        r6_ctx <= ctx;
    end

    assign o_valid = r_v[5];
    assign o_ctx   = r6_ctx;

endmodule

### rtl/core/rlb_div.sv
// Pipelined restoring divider for the three source-over colours, two
// quotient bits per stage, quotient saturated at 255. Depends on rlb_pkg.
module rlb_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  rlb_pkg::t_div_ctx    i_ctx,
    output logic                 o_valid,
    output logic                 o_use_div,
    output rlb_pkg::t_out_item   o_alt,
    output logic [rlb_pkg::ChanCount-1:0][7:0] o_quot
);
    import rlb_pkg::*;

    logic [DivStages-1:0]       r_v;
    logic                       r_use [DivStages];
    t_out_item                  r_alt [DivStages];
    logic [7:0]                 r_den [DivStages];
    logic [ChanCount-1:0][16:0] r_rem [DivStages];
    logic [ChanCount-1:0][7:0]  r_q   [DivStages];
    logic [ChanCount-1:0]       r_sat [DivStages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DivStages-2:0], i_valid};
        end
    end

    for (genvar g = 0; g < DivStages; g++) begin : g_stage
        logic                       use_in;
        t_out_item                  alt_in;
        logic [7:0]                 den_in;
        logic [ChanCount-1:0][16:0] rem_in;
        logic [ChanCount-1:0][7:0]  q_in;
        logic [ChanCount-1:0]       sat_in;

        if (g == 0) begin : g_first
            always_comb begin
                use_in = i_ctx.use_div;
                alt_in = i_ctx.alt;
                den_in = i_ctx.den;
                rem_in = i_ctx.num;
                q_in   = '0;
                for (int c = 0; c < ChanCount; c++) begin
                    sat_in[c] = (i_ctx.num[c] >= (17'(i_ctx.den) << 8));
                end
            end
        end else begin : g_next
            always_comb begin
                use_in = r_use[g-1];
                alt_in = r_alt[g-1];
                den_in = r_den[g-1];
                rem_in = r_rem[g-1];
                q_in   = r_q[g-1];
                sat_in = r_sat[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            logic [ChanCount-1:0][16:0] rem;
            logic [ChanCount-1:0][7:0]  q;
            logic [16:0]                trial;
            rem = rem_in;
            q   = q_in;
            for (int c = 0; c < ChanCount; c++) begin
                for (int j = 0; j < BitsPerStage; j++) begin
                    trial = 17'(den_in) << (7 - BitsPerStage * g - j);
                    if (rem[c] >= trial) begin
                        rem[c] = rem[c] - trial;
                        q[c][7 - BitsPerStage * g - j] = 1'b1;
                    end
                end
            end
            r_use[g] <= use_in;
            r_alt[g] <= alt_in;
            r_den[g] <= den_in;
            r_rem[g] <= rem;
            r_q[g]   <= q;
            r_sat[g] <= sat_in;
        end
    end

    always_comb begin
        for (int c = 0; c < ChanCount; c++) begin
            o_quot[c] = r_sat[DivStages-1][c] ? 8'd255 : r_q[DivStages-1][c];
        end
    end

    assign o_valid   = r_v[DivStages-1];
    assign o_use_div = r_use[DivStages-1];
    assign o_alt     = r_alt[DivStages-1];

endmodule

### rtl/core/rgba8_layer_blend.sv
// Top level of the RGBA8 layer blend: APB register file, mixing pipe,
// divider pipe and result register. Depends on rlb_pkg, rlb_mix, rlb_div.
//
// Usage:
//  - Pixel in: drive i_item (source and destination RGBA) with i_start high;
//    the pixel transfer happens on any edge with i_start high, since o_busy
//    is held low. One pixel may enter every clock.
//  - Result out: o_result carries the blended pixel and the changed flag
//    for exactly one cycle, flagged by o_done. The receiver cannot stall;
//    the pipe never holds back and needs no backpressure.
//  - Pipeline: a pixel passes 6 mixing stages, 4 divider stages and 1
//    output register on its way to o_result and o_done.
//    Throughput is one pixel per clock; the divider retires two quotient
//    bits per stage, which sets its four-stage depth.
//  - Registers (APB, 32-bit): 0x0 blend_mode, 0x4 layer_opacity. Write only
//    while no pixel is in flight. Reads return the stored value.
//  - Reset (synchronous, active low) clears all valid bits and sets mode to
//    source-over and opacity to 255. In-flight pixels are dropped.
module rgba8_layer_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // pixel channel
    input  logic                i_start,
    output logic                o_busy,
    input  rlb_pkg::t_in_item   i_item,
    output logic                o_done,
    output rlb_pkg::t_out_item  o_result,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rlb_pkg::*;

    localparam logic RegMode    = 1'b0;
    localparam logic RegOpacity = 1'b1;

    logic [2:0] r_mode;
    logic [7:0] r_opacity;

    logic       in_xfer;
    logic       mix_v;
    t_div_ctx   mix_ctx;
    logic       div_v;
    logic       div_use;
    t_out_item  div_alt;
    logic [ChanCount-1:0][7:0] div_quot;

    logic       r_done;
    t_out_item  r_result;
    t_out_item  n_result;

    assign pready  = 1'b1;
    assign o_busy  = 1'b0;
    assign in_xfer = i_start & ~o_busy;

    // register file; paddr[2] picks the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OVER;
            r_opacity <= 8'd255;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                RegMode:    r_mode    <= pwdata[2:0];
                RegOpacity: r_opacity <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            RegMode:    prdata = {29'd0, r_mode};
            RegOpacity: prdata = {24'd0, r_opacity};
            default:    prdata = '0;
        endcase
    end

    rlb_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_xfer),
        .i_item    (i_item),
        .i_mode    (r_mode),
        .i_opacity (r_opacity),
        .o_valid   (mix_v),
        .o_ctx     (mix_ctx)
    );

    rlb_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (mix_v),
        .i_ctx     (mix_ctx),
        .o_valid   (div_v),
        .o_use_div (div_use),
        .o_alt     (div_alt),
        .o_quot    (div_quot)
    );

    // source-over colours come from the divider, all else rode along
    always_comb begin
        n_result = div_alt;
        if (div_use) begin
            n_result.out_red   = div_quot[2];
            n_result.out_green = div_quot[1];
            n_result.out_blue  = div_quot[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### verif/rgba8_layer_blend_tb.sv
// Self-checking testbench for rgba8_layer_blend: pixels are driven with random
// gaps, expected pixels are predicted in the bench and compared per field.
// Depends on rlb_pkg and the rgba8_layer_blend RTL.
module rgba8_layer_blend_tb;
    import rlb_pkg::*;

    localparam int BlendLatency = 11;
    localparam logic [2:0] RegMode    = 3'd0;
    localparam logic [2:0] RegOpacity = 3'd4;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_item;
    logic        o_done;
    t_out_item   o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgba8_layer_blend DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(i_start), .o_busy(o_busy), .i_item(i_item),
        .o_done(o_done), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the two registers
    logic [2:0] cur_mode;
    logic [7:0] cur_opacity;
    // expected blended pixels, oldest first
    t_out_item  blend_expected_q[$];
    int         error_count;
    int         idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit: far beyond the slowest correct run
    initial begin
        #(12 * 400000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] clamp255(input int unsigned v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // compositing of one pixel under the current register values
    function automatic t_out_item predict_composite(input t_in_item px);
        t_out_item   res;
        int unsigned s[3], d[3], r[3];
        int unsigned sa, da, ra, inv, dw, m, k;
        s[0] = px.src_red;  s[1] = px.src_green;  s[2] = px.src_blue;
        d[0] = px.dst_red;  d[1] = px.dst_green;  d[2] = px.dst_blue;
        da = px.dst_alpha;
        sa = px.src_alpha * cur_opacity / 255;
        if (sa == 0 && cur_mode != MODE_REPLACE) begin
            // fully transparent source: destination passes through
            res.out_red = px.dst_red;  res.out_green = px.dst_green;
            res.out_blue = px.dst_blue;  res.out_alpha = px.dst_alpha;
            res.changed = 1'b0;
            return res;
        end
        ra = da;
        case (cur_mode)
            MODE_REPLACE: begin
                for (int i = 0; i < 3; i++) r[i] = s[i];
                ra = sa;
            end
            MODE_ADD: begin
                for (int i = 0; i < 3; i++) r[i] = clamp255(d[i] + s[i] * sa / 255);
                ra = clamp255(da + sa);
            end
            MODE_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    m = d[i] * s[i] / 255;
                    r[i] = (d[i] * (255 - sa) + m * sa) / 255;
                end
            end
            MODE_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    k = s[i] * sa / 255;
                    r[i] = (d[i] > k) ? d[i] - k : 0;
                end
            end
            default: begin
                // source-over, also taken by unused mode codes
                inv = 255 - sa;
                dw = da * inv / 255;
                ra = sa + dw;
                for (int i = 0; i < 3; i++)
                    r[i] = (ra == 0) ? 0 : clamp255((s[i] * sa + d[i] * da * inv / 255) / ra);
            end
        endcase
        res.out_red = r[0][7:0];  res.out_green = r[1][7:0];
        res.out_blue = r[2][7:0];  res.out_alpha = ra[7:0];
        res.changed = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // result checker: o_done marks a one-cycle result that cannot be stalled
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (blend_expected_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_out_item want;
                want = blend_expected_q.pop_front();
                if (o_result.out_red !== want.out_red)
                    report_mismatch("out_red", o_result.out_red, want.out_red);
                if (o_result.out_green !== want.out_green)
                    report_mismatch("out_green", o_result.out_green, want.out_green);
                if (o_result.out_blue !== want.out_blue)
                    report_mismatch("out_blue", o_result.out_blue, want.out_blue);
                if (o_result.out_alpha !== want.out_alpha)
                    report_mismatch("out_alpha", o_result.out_alpha, want.out_alpha);
                if (o_result.changed !== want.changed)
                    report_mismatch("changed", o_result.changed, want.changed);
            end
        end
    end

    // one pixel transfer; i_start stays high into the next call when back to back
    task automatic send_pixel(input t_in_item px);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= px;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        blend_expected_q.push_back(predict_composite(px));
    endtask

    task automatic end_burst();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for the pipe to drain before touching registers
    task automatic drain_pipe();
        int guard;
        guard = 0;
        end_burst();
        while (blend_expected_q.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (BlendLatency + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;  penable <= 1'b0;  pwrite <= 1'b1;
        paddr <= addr;  pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;
        @(posedge i_clk);
        if (addr == RegMode) cur_mode = data[2:0];
        else cur_opacity = data[7:0];
    endtask

    task automatic set_blend(input logic [2:0] mode, input logic [7:0] opacity);
        drain_pipe();
        write_reg(RegMode, {29'd0, mode});
        write_reg(RegOpacity, {24'd0, opacity});
    endtask

    function automatic t_in_item random_pixel();
        t_in_item px;
        px = {$urandom, $urandom};
        // bias the two alpha fields toward their extremes now and then
        if ($urandom_range(7) == 0) px.src_alpha = $urandom_range(1) ? 8'd255 : 8'd0;
        if ($urandom_range(7) == 0) px.dst_alpha = $urandom_range(1) ? 8'd255 : 8'd0;
        return px;
    endfunction

    // extremes of every field under every mode, including the pass-through
    // and zero-result-alpha corners, the saturating cases and unused code 7
    task automatic test_directed();
        t_in_item px;
        logic [2:0] m;
        idle_pct = 0;
        for (int mi = 0; mi < 6; mi++) begin
            m = (mi == 5) ? 3'd7 : 3'(mi);
            set_blend(m, 8'd255);
            send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0});
            send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255});
            send_pixel({8'd200, 8'd10, 8'd255, 8'd1, 8'd0, 8'd128, 8'd255, 8'd0});
            send_pixel({8'd255, 8'd255, 8'd255, 8'd128, 8'd255, 8'd255, 8'd255, 8'd255});
        end
        set_blend(MODE_OVER, 8'd0);
        px = {8'd90, 8'd80, 8'd70, 8'd255, 8'd10, 8'd20, 8'd30, 8'd0};
        send_pixel(px);
        set_blend(MODE_REPLACE, 8'd0);
        send_pixel(px);
    endtask

    // mostly random pixels across a sweep of register settings
    task automatic test_random();
        logic [7:0] opac;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: opac = 8'd255;
                1: opac = 8'd1;
                default: opac = 8'($urandom_range(255));
            endcase
            set_blend(3'($urandom_range(7)), opac);
            idle_pct = (phase == 5) ? 0 : 28;
            repeat (125) send_pixel(random_pixel());
        end
    endtask

    // register readback of both registers
    task automatic test_readback();
        drain_pipe();
        psel <= 1'b1;  penable <= 1'b0;  pwrite <= 1'b0;  paddr <= RegOpacity;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== cur_opacity) report_mismatch("opacity readback", prdata, cur_opacity);
        psel <= 1'b0;  penable <= 1'b0;
        @(posedge i_clk);
        psel <= 1'b1;  penable <= 1'b0;  pwrite <= 1'b0;  paddr <= RegMode;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[2:0] !== cur_mode) report_mismatch("mode readback", prdata, cur_mode);
        psel <= 1'b0;  penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        error_count = 0;
        idle_pct    = 0;
        cur_mode    = MODE_OVER;
        cur_opacity = 8'd255;
        i_rst_n = 1'b0;  i_start = 1'b0;  i_item = '0;
        psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset values first: source-over at full opacity
        send_pixel({8'd100, 8'd150, 8'd200, 8'd128, 8'd50, 8'd60, 8'd70, 8'd200});
        test_directed();
        test_random();
        test_readback();
        drain_pipe();
        if (error_count == 0 && blend_expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/rlb_pkg.sv
rtl/core/rlb_mix.sv
rtl/core/rlb_div.sv
rtl/core/rgba8_layer_blend.sv
verif/rgba8_layer_blend_tb.sv
